// ----- design/srrip_replacement_assert.svh -----
// Assertion macros for the SRRIP replacement engine.
// Included by srrip_ctrl, the RTL file that carries concurrent checks; no dependencies.
`ifndef SRRIP_REPLACEMENT_ASSERT_SVH
`define SRRIP_REPLACEMENT_ASSERT_SVH

`ifndef SYNTH
`define SRRIP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRRIP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRRIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRRIP_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

// ----- design/srrip_pkg.sv -----
// Shared types and constants for the SRRIP replacement engine.
// No dependencies; imported by srrip_if, srrip_ctrl, srrip_dp and srrip_replacement.
package srrip_pkg;

    localparam int SET_COUNT_DEF = 64;
    localparam int WAYS_DEF      = 8;
    localparam int RRPV_BITS_DEF = 2;

    localparam int SET_IDX_W = 6;
    localparam int WAY_IDX_W = 3;
    localparam int MASK_W    = 8;
    localparam int CFG_W     = 2;

    localparam logic [CFG_W-1:0] INSERT_RRPV_RST = 2'd2;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic age;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } dp_sts_t;

endpackage

// ----- design/srrip_if.sv -----
// Request and result channel interfaces of the SRRIP replacement engine.
// Depends on srrip_pkg for the field widths.
interface srrip_req_if import srrip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [SET_IDX_W-1:0] set_addr;
    logic [WAY_IDX_W-1:0] way_index;
    logic                 was_hit;
    logic [MASK_W-1:0]    reserved_mask;
    logic                 no_effect_access;

    modport source (
        output valid, op, set_addr, way_index, was_hit, reserved_mask, no_effect_access,
        input  ready
    );
    modport sink (
        input  valid, op, set_addr, way_index, was_hit, reserved_mask, no_effect_access,
        output ready
    );
endinterface

interface srrip_rsp_if import srrip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WAY_IDX_W-1:0] victim_way;
    logic                 victim_found;

    modport source (
        output valid, victim_way, victim_found,
        input  ready
    );
    modport sink (
        input  valid, victim_way, victim_found,
        output ready
    );
endinterface

// ----- design/srrip_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module srrip_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/srrip_ctrl.sv -----
// Controller of the SRRIP replacement engine: clear, accept, age, select.
// Depends on srrip_pkg and srrip_replacement_assert.svh.
`include "srrip_replacement_assert.svh"

module srrip_ctrl import srrip_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_AGE   = 2'd2;
    localparam logic [1:0] S_SEL   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        req_ready    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_AGE;
                end
            end
            S_AGE:
            begin
                cmd.age    = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SRRIP_ASSERT(a_load_free, clk, rst_n, cmd.load_out |-> !sts.out_busy, "pending result overwritten")
    `SRRIP_ASSERT(a_cap_age, clk, rst_n, cmd.capture |=> cmd.age, "row update did not follow read")
    `SRRIP_ASSERT(a_clr_done, clk, rst_n, (state_reg == S_CLEAR) && sts.clr_last |=> req_ready, "clear pass did not end")
    `SRRIP_ASSERT_RST(a_rst_clear, clk, !rst_n |=> (state_reg == S_CLEAR), "reset did not start clear pass")

endmodule

// ----- design/srrip_dp.sv -----
// Datapath of the SRRIP replacement engine: RRPV memory, aging, victim pick.
// Depends on srrip_pkg and srrip_ram.
module srrip_dp import srrip_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int RRPV_BITS = RRPV_BITS_DEF,
    localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 op,
    input  logic [SET_IDX_W-1:0] set_addr,
    input  logic [WAY_IDX_W-1:0] way_index,
    input  logic                 was_hit,
    input  logic [MASK_W-1:0]    reserved_mask,
    input  logic                 no_effect_access,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [WAY_IDX_W-1:0] victim_way,
    output logic                 victim_found
);

    localparam int RB       = RRPV_BITS;
    localparam int ROW_W    = WAYS * RB;
    localparam int NV       = 2 ** RB;
    localparam int WW       = $clog2(WAYS);
    localparam int MW       = (WAYS > MASK_W) ? WAYS : MASK_W;
    localparam int SET_SPAN = 2 ** SET_IDX_W;
    localparam logic [RB-1:0] RMAX = '1;

    // set_addr folded onto the implemented sets
    logic [SET_W-1:0] set_map [SET_SPAN];

    for (genvar i = 0; i < SET_SPAN; i++)
    begin : g_set_map
        assign set_map[i] = SET_W'(i % SET_COUNT);
    end

    logic [CFG_W-1:0]     insert_rrpv_reg;
    logic [RB-1:0]        ins_val;
    logic [3:0]           ins_ext;

    logic                 op_reg;
    logic [SET_W-1:0]     set_reg;
    logic [WAY_IDX_W-1:0] way_reg;
    logic                 hit_reg;
    logic [MASK_W-1:0]    mask_reg;
    logic                 noeff_reg;

    logic [SET_W-1:0]     clr_cnt_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [ROW_W-1:0]     ram_rdata;

    logic                 ram_we;
    logic [SET_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;

    logic                 out_valid_reg;
    logic [WAY_IDX_W-1:0] victim_way_reg;
    logic                 victim_found_reg;
    logic [WAY_IDX_W-1:0] sel_way;
    logic                 sel_found;

    // config register, saturated to RMAX on use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_rrpv_reg <= INSERT_RRPV_RST;
        end
        else if (cfg_we)
        begin
            insert_rrpv_reg <= cfg_wdata;
        end
    end

    assign ins_ext = 4'(insert_rrpv_reg);
    assign ins_val = (ins_ext > 4'(RMAX)) ? RMAX : RB'(ins_ext);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            set_reg   <= set_map[set_addr];
            way_reg   <= way_index;
            hit_reg   <= was_hit;
            mask_reg  <= reserved_mask;
            noeff_reg <= no_effect_access;
        end
        if (cmd.age)
        begin
            row_reg <= row_next;
        end
    end

    // clear pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == SET_W'(SET_COUNT - 1));

    assign ram_we    = cmd.clr_step | cmd.age;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : set_reg;
    assign ram_wdata = cmd.clr_step ? {ROW_W{1'b1}} : row_next;

    srrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SET_COUNT)
    ) u_rrpv_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (set_map[set_addr]),
        .rdata (ram_rdata)
    );

    // aging on victim request, way write on update
    always_comb
    begin : age_logic
        logic [RB-1:0] row_in [WAYS];
        logic [NV-1:0] present;
        logic [RB-1:0] largest;
        logic [RB-1:0] delta;
        logic [RB-1:0] upd_val;
        logic          upd_en;

        for (int w = 0; w < WAYS; w++)
        begin
            row_in[w] = ram_rdata[w*RB +: RB];
        end
        for (int v = 0; v < NV; v++)
        begin
            present[v] = 1'b0;
            for (int w = 0; w < WAYS; w++)
            begin
                present[v] = present[v] | (row_in[w] == RB'(v));
            end
        end
        largest = '0;
        for (int v = 0; v < NV; v++)
        begin
            if (present[v])
            begin
                largest = RB'(v);
            end
        end
        delta   = RMAX - largest;
        upd_val = hit_reg ? '0 : ins_val;
        upd_en  = (op_reg == OP_UPDATE) && !noeff_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (op_reg == OP_UPDATE)
            begin
                row_next[w*RB +: RB] = (upd_en && (32'(way_reg) == w)) ? upd_val : row_in[w];
            end
            else
            begin
                row_next[w*RB +: RB] = row_in[w] + delta;
            end
        end
    end

    // victim pick over unreserved ways
    always_comb
    begin : sel_logic
        logic [RB-1:0]   row_s [WAYS];
        logic [MW-1:0]   mask_ext;
        logic [WAYS-1:0] cand;
        logic [NV-1:0]   present_u;
        logic [RB-1:0]   best;
        logic [WW-1:0]   idx;

        mask_ext = MW'(mask_reg);
        for (int w = 0; w < WAYS; w++)
        begin
            row_s[w] = row_reg[w*RB +: RB];
            cand[w]  = !mask_ext[w];
        end
        for (int v = 0; v < NV; v++)
        begin
            present_u[v] = 1'b0;
            for (int w = 0; w < WAYS; w++)
            begin
                present_u[v] = present_u[v] | (cand[w] && (row_s[w] == RB'(v)));
            end
        end
        best = '0;
        for (int v = 0; v < NV; v++)
        begin
            if (present_u[v])
            begin
                best = RB'(v);
            end
        end
        idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (cand[w] && (row_s[w] == best))
            begin
                idx = WW'(w);
            end
        end
        if ((op_reg == OP_VICTIM) && (|cand))
        begin
            sel_found = 1'b1;
            sel_way   = WAY_IDX_W'(idx);
        end
        else
        begin
            sel_found = 1'b0;
            sel_way   = '0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            victim_way_reg   <= sel_way;
            victim_found_reg <= sel_found;
        end
    end

    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign victim_way   = victim_way_reg;
    assign victim_found = victim_found_reg;

endmodule

// ----- design/srrip_replacement.sv -----
// Top level of the SRRIP replacement engine.
// Depends on srrip_pkg, srrip_if, srrip_ctrl and srrip_dp.
//
// req carries victim requests (op = 0: set_addr, reserved_mask) and updates
// (op = 1: set_addr, way_index, was_hit, no_effect_access). rsp returns one
// result per request: victim_way and victim_found (both 0 for updates).
// Both channels use valid/ready; a request moves when both are high.
// cfg_we/cfg_wdata write insert_rrpv; write only while the engine is idle.
// Each request passes these steps in order: accept with the set row read from
// the RRPV memory, age or update the row and write it back, pick the victim
// into the result register. A new request is taken only after the previous
// one has loaded the result register, as the read-modify-write of the set row
// must finish first. After reset a clear pass writes every row to distant,
// with req.ready low; cfg writes are taken during it. While rsp stalls the
// result is held and the next request is still taken; that request then waits
// in the select step until the result register frees.
module srrip_replacement import srrip_pkg::*; #(
    parameter int SET_COUNT = SET_COUNT_DEF,
    parameter int WAYS      = WAYS_DEF,
    parameter int RRPV_BITS = RRPV_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    srrip_req_if.sink        req,
    srrip_rsp_if.source      rsp
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    req_ready;

    srrip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    srrip_dp #(
        .SET_COUNT (SET_COUNT),
        .WAYS      (WAYS),
        .RRPV_BITS (RRPV_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .op               (req.op),
        .set_addr         (req.set_addr),
        .way_index        (req.way_index),
        .was_hit          (req.was_hit),
        .reserved_mask    (req.reserved_mask),
        .no_effect_access (req.no_effect_access),
        .out_ready        (rsp.ready),
        .out_valid        (rsp.valid),
        .victim_way       (rsp.victim_way),
        .victim_found     (rsp.victim_found)
    );

    assign req.ready = req_ready;

endmodule
